[rtl/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(LABEL, CLK, RST_N, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(LABEL, CLK, RST_N, ANTE, CONS)
`define ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS)

`endif

`endif

[rtl/ctt_pkg.sv]
// Types and constants shared by the tokenizer modules.
`default_nettype none

package ctt_pkg;

    // Lexer modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_STR,
        MODE_STR_ESC,
        MODE_HASH,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR
    } mode_t;

    // Token type codes
    localparam logic [2:0] TOK_UNKNOWN = 3'd0;
    localparam logic [2:0] TOK_PUNCT   = 3'd1;
    localparam logic [2:0] TOK_NUMBER  = 3'd2;
    localparam logic [2:0] TOK_STRING  = 3'd3;
    localparam logic [2:0] TOK_IDENT   = 3'd4;
    localparam logic [2:0] TOK_COMMENT = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EOS   = 2'd1;
    localparam logic [1:0] ERR_SLASH = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // One result request
    typedef struct packed {
        logic [2:0] token_type;
        logic       char_valid;
        logic [7:0] char_value;
        logic       token_end;
        logic [1:0] error;
    } result_t;

    // One classified input: one or two result requests
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } item_t;

    // Candidate result before the comment filter
    typedef struct packed {
        logic    en;
        result_t res;
    } emit_t;

endpackage

`default_nettype wire

[rtl/config_text_tokenizer_unit.sv]
// Top level of the configuration text tokenizer.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   ch, end_of_input
//  out      output     out_valid / out_ready token_type, char_valid, char_value,
//                                            token_end, error, last
//  cfg      input      cfg_we                cfg_wdata (drop_comments)
//
// One byte is accepted per cycle while the request queue has a free slot.
// Results leave the out port one at a time; a byte giving two results
// holds the out port for both, so the out port sets the sustained rate.
// The first result of a byte is offered from the queue once older requests are out.
// Reset clears the lexer mode, the queue and drop_comments; in_ready falls
// once QUEUE_DEPTH requests wait behind a stalled out port.
`default_nettype none

module config_text_tokenizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      token_type,
    output logic            char_valid,
    output logic [7:0]      char_value,
    output logic            token_end,
    output logic [1:0]      error,
    output logic            last
);
    import ctt_pkg::*;

    logic    push_valid;
    item_t   push_item;
    logic    push_ready;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t out_res;

    // Classify bytes
    ctt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (push_ready)
    );

    // Decouple front and back
    ctt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop_ready  (q_pop)
    );

    // Serialise results
    ctt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .out_last  (last)
    );

    // Unpack the result fields
    assign token_type = out_res.token_type;
    assign char_valid = out_res.char_valid;
    assign char_value = out_res.char_value;
    assign token_end  = out_res.token_end;
    assign error      = out_res.error;

endmodule

`default_nettype wire

[rtl/ctt_front.sv]
// Front end: accepts bytes, runs the lexer mode machine and builds result requests.
`default_nettype none
`include "assert_macros.svh"

module ctt_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     ch,
    input  wire logic           end_of_input,
    output logic                push_valid,
    output ctt_pkg::item_t      push_item,
    input  wire logic           push_ready
);
    import ctt_pkg::*;

    mode_t mode_reg;
    mode_t mode_next;
    logic  drop_comments_reg;
    logic  accept;
    emit_t e0;
    emit_t e1;
    logic  keep0;
    logic  keep1;

    // Character classes
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {"{", "}", "<", ">", "[", "]", "(", ")", ";", ":", ",", "="};
    endfunction

    function automatic logic is_num_start(input logic [7:0] c);
        return is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    // Result builders
    function automatic emit_t mk_char(input logic [2:0] tt, input logic [7:0] c);
        emit_t e;
        e.en             = 1'b1;
        e.res.token_type = tt;
        e.res.char_valid = 1'b1;
        e.res.char_value = c;
        e.res.token_end  = 1'b0;
        e.res.error      = ERR_NONE;
        return e;
    endfunction

    function automatic emit_t mk_single(input logic [2:0] tt, input logic [7:0] c);
        emit_t e;
        e               = mk_char(tt, c);
        e.res.token_end = 1'b1;
        return e;
    endfunction

    function automatic emit_t mk_end(input logic [2:0] tt);
        emit_t e;
        e.en             = 1'b1;
        e.res.token_type = tt;
        e.res.char_valid = 1'b0;
        e.res.char_value = 8'd0;
        e.res.token_end  = 1'b1;
        e.res.error      = ERR_NONE;
        return e;
    endfunction

    function automatic emit_t mk_err(input logic [1:0] code);
        emit_t e;
        e           = mk_end(TOK_COMMENT);
        e.res.error = code;
        return e;
    endfunction

    // Mode and result of a byte seen between tokens
    function automatic mode_t start_mode(input logic [7:0] c);
        mode_t m;
        m = MODE_IDLE;
        if (is_space(c) || is_punct(c))
            m = MODE_IDLE;
        else if (is_num_start(c))
            m = MODE_NUM;
        else if (c == CH_QUOTE)
            m = MODE_STR;
        else if (c == CH_HASH)
            m = MODE_HASH;
        else if (c == CH_SLASH)
            m = MODE_SLASH;
        else if (is_ident_start(c))
            m = MODE_IDENT;
        return m;
    endfunction

    function automatic emit_t start_emit(input logic [7:0] c);
        emit_t e;
        e = '0;
        if (is_space(c))
            e = '0;
        else if (is_punct(c))
            e = mk_single(TOK_PUNCT, c);
        else if (is_num_start(c))
            e = mk_char(TOK_NUMBER, c);
        else if ((c == CH_QUOTE) || (c == CH_HASH) || (c == CH_SLASH))
            e = '0;
        else if (is_ident_start(c))
            e = mk_char(TOK_IDENT, c);
        else
            e = mk_single(TOK_UNKNOWN, c);
        return e;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c == CH_LOWER_N)
            v = CH_LF;
        else if (c == CH_LOWER_R)
            v = CH_CR;
        else if (c == CH_LOWER_T)
            v = CH_TAB;
        return v;
    endfunction

    // Take a byte whenever the queue has room
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Next lexer mode
    always_comb
    begin
        mode_next = mode_reg;
        if (end_of_input)
        begin
            mode_next = MODE_IDLE;
        end
        else
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit(ch) || (ch == CH_DOT) || (ch == CH_PLUS) || (ch == CH_MINUS))
                        mode_next = MODE_NUM;
                    else
                        mode_next = start_mode(ch);
                end
                MODE_IDENT:
                begin
                    if (is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER))
                        mode_next = MODE_IDENT;
                    else
                        mode_next = start_mode(ch);
                end
                MODE_STR:
                begin
                    if (ch == CH_QUOTE)
                        mode_next = MODE_IDLE;
                    else if (ch == CH_BSLASH)
                        mode_next = MODE_STR_ESC;
                    else
                        mode_next = MODE_STR;
                end
                MODE_STR_ESC:
                    mode_next = MODE_STR;
                MODE_HASH, MODE_LINE:
                begin
                    if (ch == CH_LF)
                        mode_next = MODE_IDLE;
                    else
                        mode_next = mode_reg;
                end
                MODE_SLASH:
                begin
                    if (ch == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (ch == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (ch == CH_STAR)
                        mode_next = MODE_STAR;
                    else
                        mode_next = MODE_BLOCK;
                end
                MODE_STAR:
                begin
                    if (ch == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else
                        mode_next = MODE_BLOCK;
                end
                default:
                    mode_next = start_mode(ch);
            endcase
        end
    end

    // Candidate results for this byte
    always_comb
    begin
        e0 = '0;
        e1 = '0;
        if (end_of_input)
        begin
            case (mode_reg)
                MODE_NUM:                         e0 = mk_end(TOK_NUMBER);
                MODE_IDENT:                       e0 = mk_end(TOK_IDENT);
                MODE_STR, MODE_STR_ESC:           e0 = mk_end(TOK_STRING);
                MODE_HASH, MODE_LINE, MODE_BLOCK: e0 = mk_end(TOK_COMMENT);
                MODE_SLASH, MODE_STAR:            e0 = mk_err(ERR_EOS);
                default:                          e0 = '0;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit(ch) || (ch == CH_DOT) || (ch == CH_PLUS) || (ch == CH_MINUS))
                    begin
                        e0 = mk_char(TOK_NUMBER, ch);
                    end
                    else
                    begin
                        e0 = mk_end(TOK_NUMBER);
                        e1 = start_emit(ch);
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER))
                    begin
                        e0 = mk_char(TOK_IDENT, ch);
                    end
                    else
                    begin
                        e0 = mk_end(TOK_IDENT);
                        e1 = start_emit(ch);
                    end
                end
                MODE_STR:
                begin
                    if (ch == CH_QUOTE)
                        e0 = mk_end(TOK_STRING);
                    else if (ch != CH_BSLASH)
                        e0 = mk_char(TOK_STRING, ch);
                end
                MODE_STR_ESC:
                    e0 = mk_char(TOK_STRING, unescape(ch));
                MODE_HASH, MODE_LINE:
                begin
                    if (ch == CH_LF)
                        e0 = mk_end(TOK_COMMENT);
                    else
                        e0 = mk_char(TOK_COMMENT, ch);
                end
                MODE_SLASH:
                begin
                    if ((ch != CH_SLASH) && (ch != CH_STAR))
                        e0 = mk_err(ERR_SLASH);
                end
                MODE_BLOCK:
                begin
                    if (ch != CH_STAR)
                        e0 = mk_char(TOK_COMMENT, ch);
                end
                MODE_STAR:
                begin
                    if (ch == CH_SLASH)
                    begin
                        e0 = mk_end(TOK_COMMENT);
                    end
                    else
                    begin
                        e0 = mk_char(TOK_COMMENT, CH_STAR);
                        e1 = mk_char(TOK_COMMENT, ch);
                    end
                end
                default:
                    e0 = start_emit(ch);
            endcase
        end
    end

    // Drop comment results when asked, keep error results
    assign keep0 = e0.en && !((e0.res.token_type == TOK_COMMENT) && drop_comments_reg &&
                              (e0.res.error == ERR_NONE));
    assign keep1 = e1.en && !((e1.res.token_type == TOK_COMMENT) && drop_comments_reg &&
                              (e1.res.error == ERR_NONE));

    // Pack the surviving results into one queue request
    assign push_valid       = accept && (keep0 || keep1);
    assign push_item.two    = keep0 && keep1;
    assign push_item.first  = keep0 ? e0.res : e1.res;
    assign push_item.second = e1.res;

    // Hold mode and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            drop_comments_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                mode_reg <= mode_next;
            if (cfg_we)
                drop_comments_reg <= cfg_wdata;
        end
    end

    `ASSERT_NEXT(a_eoi_to_idle, clk, rst_n, accept && end_of_input, mode_reg == MODE_IDLE)

endmodule

`default_nettype wire

[rtl/ctt_queue.sv]
// Short queue of classified requests between front end and back end.
`default_nettype none
`include "assert_macros.svh"

module ctt_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  wire ctt_pkg::item_t push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output ctt_pkg::item_t      pop_item,
    input  wire logic           pop_ready
);
    import ctt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    item_t         store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          push_fire;
    logic          pop_fire;

    // Status
    assign full       = (count_reg == FULL_COUNT);
    assign push_ready = !full;
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && !full;
    assign pop_fire   = pop_ready && pop_valid;
    assign pop_item   = store_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CW'(push_fire) - CW'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push_fire)
            store_reg[wr_ptr_reg] <= push_item;
    end

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push_valid, !full)
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop_ready, pop_valid)

endmodule

`default_nettype wire

[rtl/ctt_back.sv]
// Back end: walks each queued request and hands out its results one at a time.
`default_nettype none
`include "assert_macros.svh"

module ctt_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire ctt_pkg::item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ctt_pkg::result_t    out_res,
    output logic                out_last
);
    import ctt_pkg::*;

    logic idx_reg;
    logic idx_next;
    logic fire;

    // Select the current result of the head request
    assign out_valid = q_valid;
    assign out_res   = idx_reg ? q_item.second : q_item.first;
    assign out_last  = idx_reg || !q_item.two;
    assign fire      = out_valid && out_ready;
    assign q_pop     = fire && out_last;

    // Step to the second result or back to the first of the next request
    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = !out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 1'b0;
        else
            idx_reg <= idx_next;
    end

    `ASSERT_IMPLIES(a_second_needs_pair, clk, rst_n, idx_reg, q_valid && q_item.two)

endmodule

`default_nettype wire

[verif/config_text_tokenizer_unit_tb.sv]
// Self-checking testbench for the configuration text tokenizer unit.

module config_text_tokenizer_unit_tb;

    import ctt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 140;
    localparam int TAIL_CYCLES  = 12;
    localparam int STALL_CYCLES = 60;

    // One result request as seen on the out port
    typedef struct packed {
        logic [2:0] kind;
        logic       has_char;
        logic [7:0] value;
        logic       closes;
        logic [1:0] err;
        logic       last;
    } token_beat_t;

    // Lexer predictor plus the queue of result requests still owed by the block
    class tokenizer_scoreboard;
        mode_t       mode;
        bit          drop;
        int          errors;
        token_beat_t owed[$];
        token_beat_t step_beats[$];

        function new();
            mode   = MODE_IDLE;
            drop   = 1'b0;
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 20)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_mark(logic [7:0] c);
            return c == "{" || c == "}" || c == "<" || c == ">" || c == "[" ||
                   c == "]" || c == "(" || c == ")" || c == ";" || c == ":" ||
                   c == "," || c == "=";
        endfunction

        // Drop comment beats when asked, but never error beats
        function void emit_beat(logic [2:0] kind, logic has_char, logic [7:0] value,
                                logic closes, logic [1:0] err);
            token_beat_t b;
            if (kind == TOK_COMMENT && drop && err == ERR_NONE)
                return;
            b.kind     = kind;
            b.has_char = has_char;
            b.value    = has_char ? value : 8'h00;
            b.closes   = closes;
            b.err      = err;
            b.last     = 1'b0;
            step_beats.push_back(b);
        endfunction

        function void open_token(logic [7:0] c);
            mode = MODE_IDLE;
            if (is_space(c))
                return;
            if (is_mark(c))
                emit_beat(TOK_PUNCT, 1'b1, c, 1'b1, ERR_NONE);
            else if (c == CH_PLUS || c == CH_MINUS || is_digit(c))
            begin
                mode = MODE_NUM;
                emit_beat(TOK_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
            end
            else if (c == CH_QUOTE)
                mode = MODE_STR;
            else if (c == CH_HASH)
                mode = MODE_HASH;
            else if (c == CH_SLASH)
                mode = MODE_SLASH;
            else if (is_letter(c) || c == CH_UNDER)
            begin
                mode = MODE_IDENT;
                emit_beat(TOK_IDENT, 1'b1, c, 1'b0, ERR_NONE);
            end
            else
                emit_beat(TOK_UNKNOWN, 1'b1, c, 1'b1, ERR_NONE);
        endfunction

        function void close_stream();
            case (mode)
                MODE_NUM:   emit_beat(TOK_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
                MODE_IDENT: emit_beat(TOK_IDENT, 1'b0, 8'h00, 1'b1, ERR_NONE);
                MODE_STR, MODE_STR_ESC:
                    emit_beat(TOK_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
                MODE_HASH, MODE_LINE, MODE_BLOCK:
                    emit_beat(TOK_COMMENT, 1'b0, 8'h00, 1'b1, ERR_NONE);
                MODE_SLASH, MODE_STAR:
                    emit_beat(TOK_COMMENT, 1'b0, 8'h00, 1'b1, ERR_EOS);
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        function void lex_byte(logic [7:0] c);
            logic [7:0] decoded;
            case (mode)
                MODE_NUM:
                    if (is_digit(c) || c == CH_DOT || c == CH_PLUS || c == CH_MINUS)
                        emit_beat(TOK_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
                    else
                    begin
                        emit_beat(TOK_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        open_token(c);
                    end
                MODE_IDENT:
                    if (is_letter(c) || is_digit(c) || c == CH_UNDER)
                        emit_beat(TOK_IDENT, 1'b1, c, 1'b0, ERR_NONE);
                    else
                    begin
                        emit_beat(TOK_IDENT, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        open_token(c);
                    end
                MODE_STR:
                    if (c == CH_QUOTE)
                    begin
                        emit_beat(TOK_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    else if (c == CH_BSLASH)
                        mode = MODE_STR_ESC;
                    else
                        emit_beat(TOK_STRING, 1'b1, c, 1'b0, ERR_NONE);
                MODE_STR_ESC:
                begin
                    decoded = c;
                    if (c == CH_LOWER_N)
                        decoded = CH_LF;
                    else if (c == CH_LOWER_R)
                        decoded = CH_CR;
                    else if (c == CH_LOWER_T)
                        decoded = CH_TAB;
                    emit_beat(TOK_STRING, 1'b1, decoded, 1'b0, ERR_NONE);
                    mode = MODE_STR;
                end
                MODE_HASH, MODE_LINE:
                    if (c == CH_LF)
                    begin
                        emit_beat(TOK_COMMENT, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    else
                        emit_beat(TOK_COMMENT, 1'b1, c, 1'b0, ERR_NONE);
                MODE_SLASH:
                    if (c == CH_SLASH)
                        mode = MODE_LINE;
                    else if (c == CH_STAR)
                        mode = MODE_BLOCK;
                    else
                    begin
                        emit_beat(TOK_COMMENT, 1'b0, 8'h00, 1'b1, ERR_SLASH);
                        mode = MODE_IDLE;
                    end
                MODE_BLOCK:
                    if (c == CH_STAR)
                        mode = MODE_STAR;
                    else
                        emit_beat(TOK_COMMENT, 1'b1, c, 1'b0, ERR_NONE);
                MODE_STAR:
                    if (c == CH_SLASH)
                    begin
                        emit_beat(TOK_COMMENT, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    else
                    begin
                        // A star not closing the comment is content, and so is the byte after it
                        emit_beat(TOK_COMMENT, 1'b1, CH_STAR, 1'b0, ERR_NONE);
                        emit_beat(TOK_COMMENT, 1'b1, c, 1'b0, ERR_NONE);
                        mode = MODE_BLOCK;
                    end
                default:
                    open_token(c);
            endcase
        endfunction

        // Note one accepted input request and queue the results it owes
        function void note_request(logic [7:0] c, logic eoi);
            token_beat_t b;
            step_beats.delete();
            if (eoi)
                close_stream();
            else
                lex_byte(c);
            foreach (step_beats[i])
            begin
                b = step_beats[i];
                b.last = (i == step_beats.size() - 1);
                owed.push_back(b);
            end
        endfunction

        // Compare one accepted result with the oldest owed one
        task check_result(token_beat_t got);
            token_beat_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected result type=%0d cv=%0b val=%02h end=%0b err=%0d last=%0b",
                                 got.kind, got.has_char, got.value, got.closes, got.err, got.last));
                return;
            end
            want = owed.pop_front();
            if (got.kind !== want.kind || got.has_char !== want.has_char ||
                got.value !== want.value || got.closes !== want.closes ||
                got.err !== want.err || got.last !== want.last)
                report($sformatf({"got type=%0d cv=%0b val=%02h end=%0b err=%0d last=%0b, ",
                                  "want type=%0d cv=%0b val=%02h end=%0b err=%0d last=%0b"},
                                 got.kind, got.has_char, got.value, got.closes, got.err,
                                 got.last, want.kind, want.has_char, want.value, want.closes,
                                 want.err, want.last));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] ch;
    logic       end_of_input;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] token_type;
    logic       char_valid;
    logic [7:0] char_value;
    logic       token_end;
    logic [1:0] error;
    logic       last;

    tokenizer_scoreboard sb;
    int cycles;
    int items_sent;
    int send_gap_pct;
    int recv_gap_pct;
    int hold_left;

    config_text_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_type   (token_type),
        .char_valid   (char_valid),
        .char_value   (char_value),
        .token_end    (token_end),
        .error        (error),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drive out_ready: a long hold-off when asked, otherwise random stalls
    always
    begin
        @(negedge clk);
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= recv_gap_pct);
    end

    // Check accepted results and guard against a hung run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (out_valid && out_ready)
                sb.check_result('{token_type, char_valid, char_value, token_end, error, last});
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[config_text_tokenizer_unit] ERROR");
                $finish;
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_byte(logic [7:0] c, logic eoi);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        ch           = c;
        end_of_input = eoi;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, eoi);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] space_char();
        return $urandom_range(1) ? CH_SPACE : 8'($urandom_range(13, 9));
    endfunction

    // Draw one random byte
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // Drop valid and wait until every owed result has arrived
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_drop(bit v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(posedge clk);
        sb.drop = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Send one random token: mostly well formed, some noise and broken ones
    task automatic send_random_token();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(99);
        n    = $urandom_range(6);
        if (pick < 8)
            send_byte(pick_char("{}<>[]();:,="), 1'b0);
        else if (pick < 20)
        begin
            send_byte(pick_char("+-0123456789"), 1'b0);
            repeat (n) send_byte(pick_char("0123456789.+-"), 1'b0);
        end
        else if (pick < 32)
        begin
            send_byte(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"), 1'b0);
            repeat (n)
                send_byte(pick_char("abcxyzABCXYZ0123456789_"), 1'b0);
        end
        else if (pick < 44)
        begin
            send_byte(CH_QUOTE, 1'b0);
            repeat (n)
            begin
                b = any_byte();
                if ($urandom_range(4) == 0)
                begin
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte($urandom_range(1) ? pick_char("nrt") : b, 1'b0);
                end
                else
                begin
                    if (b == CH_QUOTE || b == CH_BSLASH)
                        send_byte(CH_BSLASH, 1'b0);
                    send_byte(b, 1'b0);
                end
            end
            send_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 60)
        begin
            if (pick < 52)
                send_byte(CH_HASH, 1'b0);
            else
                send_text("//");
            repeat (n)
            begin
                b = any_byte();
                send_byte(b == CH_LF ? CH_SPACE : b, 1'b0);
            end
            send_byte(CH_LF, 1'b0);
        end
        else if (pick < 70)
        begin
            send_text("/*");
            repeat (n)
            begin
                b = any_byte();
                if ($urandom_range(3) == 0)
                begin
                    send_byte(CH_STAR, 1'b0);
                    b = $urandom_range(1) ? CH_STAR : b;
                    send_byte(b == CH_SLASH ? CH_STAR : b, 1'b0);
                end
                else
                    send_byte(b == CH_STAR ? CH_SPACE : b, 1'b0);
            end
            send_text("*/");
        end
        else if (pick < 78)
            repeat (n + 1) send_byte(space_char(), 1'b0);
        else if (pick < 86)
            send_byte(any_byte(), 1'b0);
        else if (pick < 93)
        begin
            // Broken sequences: bad byte after a slash, or the stream ending mid-token
            case ($urandom_range(3))
                0: begin
                    send_byte(CH_SLASH, 1'b0);
                    send_byte(any_byte(), 1'b0);
                end
                1: begin
                    send_byte(CH_SLASH, 1'b0);
                    send_byte(any_byte(), 1'b1);
                end
                2: begin
                    send_text("/*x*");
                    send_byte(any_byte(), 1'b1);
                end
                default: begin
                    send_text("\"a\\");
                    send_byte(any_byte(), 1'b1);
                end
            endcase
        end
        else
            send_byte(any_byte(), 1'b1);
        if ($urandom_range(1))
            send_byte(space_char(), 1'b0);
    endtask

    initial
    begin
        bit pressed;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        in_valid     = 1'b0;
        ch           = 8'h00;
        end_of_input = 1'b0;
        out_ready    = 1'b0;
        cycles       = 0;
        items_sent   = 0;
        hold_left    = 0;
        pressed      = 1'b0;
        sb           = new();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: comments kept, sender idles a third, receiver half
        send_gap_pct = 33;
        recv_gap_pct = 50;
        write_drop(1'b0);
        send_text("{-1.a_ \"\\r\\q\"#x\n/*a*b*/");
        send_text("/!");
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);
        while (items_sent < PHASE_ITEMS + 30)
            send_random_token();
        drain();

        // Phase two: comments dropped, idling swapped
        send_gap_pct = 50;
        recv_gap_pct = 33;
        write_drop(1'b1);
        while (items_sent < 2 * PHASE_ITEMS + 30)
            send_random_token();
        drain();

        // Phase three: comments kept, no idling, one long receiver hold-off
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_drop(1'b0);
        while (items_sent < 3 * PHASE_ITEMS + 30)
        begin
            if (!pressed && items_sent >= 2 * PHASE_ITEMS + 60)
            begin
                hold_left = STALL_CYCLES;
                pressed   = 1'b1;
            end
            send_random_token();
        end
        send_byte(8'h00, 1'b1);
        drain();

        if (sb.errors == 0)
            $display("[config_text_tokenizer_unit] OK");
        else
            $display("[config_text_tokenizer_unit] ERROR");
        $finish;
    end

endmodule
